// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file pidaw_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pidaw_pkg.sv =====
// Types, constants and saturation helpers for the anti-windup PID controller.
// No dependencies.
package pidaw_pkg;

    localparam int SAMPLE_WIDTH      = 16;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int ALPHA_BITS        = 16;
    localparam int REG_ADDR_WIDTH    = 3;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int FILT_WIDTH        = 40;
    localparam int MUL_WIDTH         = 33;

    localparam logic [ALPHA_BITS:0]   ALPHA_ONE     = 17'd65536;
    localparam logic signed [15:0]    DRIVE_MIN_RST = -16'sd32768;
    localparam logic signed [15:0]    DRIVE_MAX_RST = 16'sd32767;
    localparam logic signed [31:0]    ACCUM_MIN_RST = 32'sh8000_0000;
    localparam logic signed [31:0]    ACCUM_MAX_RST = 32'sh7FFF_FFFF;

    localparam logic signed [63:0] FILT_MAX = (64'sd1 <<< (FILT_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] FILT_MIN = -(64'sd1 <<< (FILT_WIDTH - 1));
    localparam logic signed [63:0] TERM_LIM = 64'sd1 <<< 61;
    localparam logic signed [32:0] WORD_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] WORD_MIN = -33'sh0_8000_0000;

    typedef enum logic [REG_ADDR_WIDTH-1:0] {
        REG_PROP_GAIN,
        REG_INT_GAIN,
        REG_DERIV_GAIN,
        REG_DERIV_ALPHA,
        REG_DRIVE_MIN,
        REG_DRIVE_MAX,
        REG_ACCUM_MIN,
        REG_ACCUM_MAX
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_FILT_HI,
        ST_FILT_LO,
        ST_FILT_ADD,
        ST_DER_HI,
        ST_DER_LO,
        ST_PROP,
        ST_INT_CAND,
        ST_INT_FLAG,
        ST_INT_MUL,
        ST_ROUND,
        ST_FIN
    } step_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] measured;
        logic signed [SAMPLE_WIDTH-1:0] target;
        logic                           clear_state;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] drive;
        logic                           sat_high;
        logic                           sat_low;
        logic                           integrated;
        logic                           status;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0]     prop_gain;
        logic signed [31:0]     int_gain;
        logic signed [31:0]     deriv_gain;
        logic [ALPHA_BITS:0]    deriv_alpha;
        logic signed [15:0]     drive_min;
        logic signed [15:0]     drive_max;
        logic signed [31:0]     accum_min;
        logic signed [31:0]     accum_max;
        logic                   bad;
    } cfg_t;

    typedef struct packed {
        step_t step;
        logic  load;
    } dp_ctrl_t;

    function automatic logic signed [FILT_WIDTH-1:0] sat_filt(input logic signed [63:0] x);
        if (x > FILT_MAX)
            return FILT_MAX[FILT_WIDTH-1:0];
        else if (x < FILT_MIN)
            return FILT_MIN[FILT_WIDTH-1:0];
        else
            return x[FILT_WIDTH-1:0];
    endfunction

    function automatic logic signed [63:0] sat_term(input logic signed [63:0] x);
        if (x > TERM_LIM)
            return TERM_LIM;
        else if (x < -TERM_LIM)
            return -TERM_LIM;
        else
            return x;
    endfunction

    function automatic logic signed [31:0] sat_word(input logic signed [32:0] x);
        if (x > WORD_MAX)
            return WORD_MAX[31:0];
        else if (x < WORD_MIN)
            return WORD_MIN[31:0];
        else
            return x[31:0];
    endfunction

endpackage

// ===== hdl/pidaw_regs.sv =====
// Configuration register file and limit check for the PID controller.
// Depends on pidaw_pkg.
module pidaw_regs (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr,
    input  logic [pidaw_pkg::REG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [pidaw_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output pidaw_pkg::cfg_t                         cfg
);
    import pidaw_pkg::*;

    logic signed [31:0]  prop_gain_reg;
    logic signed [31:0]  int_gain_reg;
    logic signed [31:0]  deriv_gain_reg;
    logic [ALPHA_BITS:0] deriv_alpha_reg;
    logic signed [15:0]  drive_min_reg;
    logic signed [15:0]  drive_max_reg;
    logic signed [31:0]  accum_min_reg;
    logic signed [31:0]  accum_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            int_gain_reg    <= '0;
            deriv_gain_reg  <= '0;
            deriv_alpha_reg <= ALPHA_ONE;
            drive_min_reg   <= DRIVE_MIN_RST;
            drive_max_reg   <= DRIVE_MAX_RST;
            accum_min_reg   <= ACCUM_MIN_RST;
            accum_max_reg   <= ACCUM_MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[31:0];
                REG_INT_GAIN:    int_gain_reg    <= cfg_data[31:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[31:0];
                REG_DERIV_ALPHA: deriv_alpha_reg <= cfg_data[ALPHA_BITS:0];
                REG_DRIVE_MIN:   drive_min_reg   <= cfg_data[15:0];
                REG_DRIVE_MAX:   drive_max_reg   <= cfg_data[15:0];
                REG_ACCUM_MIN:   accum_min_reg   <= cfg_data[31:0];
                REG_ACCUM_MAX:   accum_max_reg   <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.prop_gain   = prop_gain_reg;
        cfg.int_gain    = int_gain_reg;
        cfg.deriv_gain  = deriv_gain_reg;
        cfg.deriv_alpha = deriv_alpha_reg;
        cfg.drive_min   = drive_min_reg;
        cfg.drive_max   = drive_max_reg;
        cfg.accum_min   = accum_min_reg;
        cfg.accum_max   = accum_max_reg;
        cfg.bad         = (drive_min_reg >= drive_max_reg) || (accum_min_reg >= accum_max_reg);
    end

endmodule

// ===== hdl/pidaw_datapath.sv =====
// Datapath of the PID controller: one shared 33x33 multiplier, accumulators
// and the controller state. Sequenced by the top level. Depends on pidaw_pkg.
module pidaw_datapath #(
    parameter int GAIN_FRAC_BITS = pidaw_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidaw_pkg::dp_ctrl_t   ctrl,
    input  pidaw_pkg::in_item_t   in_item,
    input  pidaw_pkg::cfg_t       cfg,
    output pidaw_pkg::out_item_t  result
);
    import pidaw_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (GAIN_FRAC_BITS - 1);

    // controller state
    logic signed [31:0]           error_sum_reg;
    logic signed [SW-1:0]         last_measured_reg;
    logic signed [FILT_WIDTH-1:0] filt_reg;

    // per-sample working registers
    logic signed [SW-1:0]         measured_reg;
    logic signed [SW-1:0]         target_reg;
    logic signed [31:0]           err_reg;
    logic signed [FILT_WIDTH:0]   diff_reg;
    logic signed [31:0]           cand_reg;
    logic signed [63:0]           prod_reg;
    logic signed [63:0]           acc_reg;
    logic signed [63:0]           pd_reg;
    logic                         high_reg;
    logic                         low_reg;
    logic                         allow_reg;
    out_item_t                    res_reg;

    logic [ALPHA_BITS:0]          alpha_c;
    logic signed [SW:0]           meas_delta;
    logic signed [FILT_WIDTH-1:0] raw_w;
    logic signed [31:0]           err_w;
    logic signed [32:0]           sum_w;
    logic signed [31:0]           cand_w;
    logic signed [FILT_WIDTH:0]   diff_w;
    logic signed [24:0]           diff_hi;
    logic signed [23:0]           filt_hi;
    logic signed [63:0]           filt_sum;
    logic signed [63:0]           term_w;
    logic signed [63:0]           total_w;
    logic signed [63:0]           hi_q;
    logic signed [63:0]           lo_q;
    logic                         high_w;
    logic                         low_w;
    logic                         allow_w;
    logic signed [63:0]           out_q;
    logic signed [63:0]           drive_w;
    logic signed [MUL_WIDTH-1:0]  mul_a;
    logic signed [MUL_WIDTH-1:0]  mul_b;
    logic signed [2*MUL_WIDTH-1:0] prod_w;

    always_comb
    begin
        alpha_c    = (cfg.deriv_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.deriv_alpha;
        meas_delta = (SW+1)'(last_measured_reg) - (SW+1)'(measured_reg);
        raw_w      = sat_filt(64'(meas_delta) <<< ALPHA_BITS);
        err_w      = sat_word(33'(target_reg) - 33'(measured_reg));
        sum_w      = 33'(error_sum_reg) + 33'(err_w);
        if (sum_w > 33'($signed(cfg.accum_max)))
            cand_w = cfg.accum_max;
        else if (sum_w < 33'($signed(cfg.accum_min)))
            cand_w = cfg.accum_min;
        else
            cand_w = sum_w[31:0];
        diff_w  = (FILT_WIDTH+1)'(raw_w) - (FILT_WIDTH+1)'(filt_reg);
        diff_hi = diff_reg[FILT_WIDTH:ALPHA_BITS];
        filt_hi = filt_reg[FILT_WIDTH-1:ALPHA_BITS];

        filt_sum = acc_reg + (prod_reg >>> ALPHA_BITS) + 64'(filt_reg);
        term_w   = sat_term(prod_reg);
        total_w  = pd_reg + term_w;
        hi_q     = 64'($signed(cfg.drive_max)) <<< GAIN_FRAC_BITS;
        lo_q     = 64'($signed(cfg.drive_min)) <<< GAIN_FRAC_BITS;
        high_w   = total_w > hi_q;
        low_w    = total_w < lo_q;
        allow_w  = (!high_w && !low_w) || (high_w && (err_reg < 0)) || (low_w && (err_reg > 0));
        if (total_w > hi_q)
            out_q = hi_q;
        else if (total_w < lo_q)
            out_q = lo_q;
        else
            out_q = total_w;
        drive_w = (out_q + HALF_LSB) >>> GAIN_FRAC_BITS;

        mul_a = '0;
        mul_b = '0;
        case (ctrl.step)
            ST_FILT_HI:
            begin
                mul_a = MUL_WIDTH'($signed({1'b0, alpha_c}));
                mul_b = MUL_WIDTH'(diff_hi);
            end
            ST_FILT_LO:
            begin
                mul_a = MUL_WIDTH'($signed({1'b0, alpha_c}));
                mul_b = MUL_WIDTH'($signed({1'b0, diff_reg[ALPHA_BITS-1:0]}));
            end
            ST_DER_HI:
            begin
                mul_a = MUL_WIDTH'($signed(cfg.deriv_gain));
                mul_b = MUL_WIDTH'(filt_hi);
            end
            ST_DER_LO:
            begin
                mul_a = MUL_WIDTH'($signed(cfg.deriv_gain));
                mul_b = MUL_WIDTH'($signed({1'b0, filt_reg[ALPHA_BITS-1:0]}));
            end
            ST_PROP:
            begin
                mul_a = MUL_WIDTH'($signed(cfg.prop_gain));
                mul_b = MUL_WIDTH'(err_reg);
            end
            ST_INT_CAND:
            begin
                mul_a = MUL_WIDTH'($signed(cfg.int_gain));
                mul_b = MUL_WIDTH'(cand_reg);
            end
            ST_INT_MUL:
            begin
                mul_a = MUL_WIDTH'($signed(cfg.int_gain));
                mul_b = MUL_WIDTH'(error_sum_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_w = mul_a * mul_b;
    end

    // state: cleared on reset and by a clear sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg     <= '0;
            last_measured_reg <= '0;
            filt_reg          <= '0;
        end
        else if (ctrl.load && in_item.clear_state)
        begin
            error_sum_reg     <= '0;
            last_measured_reg <= '0;
            filt_reg          <= '0;
        end
        else
        begin
            case (ctrl.step)
                ST_FILT_ADD: filt_reg <= sat_filt(filt_sum);
                ST_INT_FLAG:
                begin
                    if (allow_w)
                        error_sum_reg <= cand_reg;
                end
                ST_ROUND:    last_measured_reg <= measured_reg;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_w[63:0];
        if (ctrl.load)
        begin
            measured_reg       <= in_item.measured;
            target_reg         <= in_item.target;
            res_reg.drive      <= '0;
            res_reg.sat_high   <= 1'b0;
            res_reg.sat_low    <= 1'b0;
            res_reg.integrated <= 1'b0;
            res_reg.status     <= cfg.bad;
        end
        case (ctrl.step)
            ST_PREP:
            begin
                err_reg  <= err_w;
                diff_reg <= diff_w;
                cand_reg <= cand_w;
            end
            ST_FILT_LO:  acc_reg <= prod_reg;
            ST_DER_LO:   acc_reg <= prod_reg;
            ST_PROP:     acc_reg <= sat_term(acc_reg + (prod_reg >>> ALPHA_BITS));
            ST_INT_CAND: pd_reg  <= acc_reg + term_w;
            ST_INT_FLAG:
            begin
                high_reg  <= high_w;
                low_reg   <= low_w;
                allow_reg <= allow_w;
            end
            ST_ROUND:
            begin
                res_reg.drive      <= drive_w[SW-1:0];
                res_reg.sat_high   <= high_reg;
                res_reg.sat_low    <= low_reg;
                res_reg.integrated <= allow_reg;
                res_reg.status     <= 1'b0;
            end
            default: ;
        endcase
    end

    assign result = res_reg;

endmodule

// ===== hdl/pid_controller_antiwindup.sv =====
// Top level of the anti-windup PID controller: handshake, step sequencer,
// output register. Depends on pidaw_pkg, pidaw_regs and pidaw_datapath.
//
// One sample in, one drive value out. A normal sample keeps the block busy
// (in_stall high) from its input transfer until it is back in idle: the seven
// products of the step (filter update, derivative, proportional, candidate
// and final integral terms) go one after another through a single shared
// 33x33 multiplier, with adds, saturation and the clamp and rounding between
// them. A clear sample, or any sample while the limits are invalid, goes
// straight to the last step. The result sits in an output register, so a new
// sample is taken while an earlier result still waits; a finished result then
// waits at the last step until the output register is free. Configuration
// writes take effect at once and are meant for idle periods only.
module pid_controller_antiwindup #(
    parameter int GAIN_FRAC_BITS = pidaw_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr,
    input  logic [pidaw_pkg::REG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [pidaw_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  pidaw_pkg::in_item_t                     in_data,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output pidaw_pkg::out_item_t                    out_data
);
    import pidaw_pkg::*;

    cfg_t      cfg;
    dp_ctrl_t  ctrl;
    out_item_t result;
    step_t     step_reg;
    step_t     step_next;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      out_free;

    pidaw_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    pidaw_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_item (in_data),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_IDLE;
        else
            step_reg <= step_next;
    end

    always_comb
    begin
        step_next = step_reg;
        ctrl.load = 1'b0;
        ctrl.step = step_reg;
        case (step_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    step_next = (in_data.clear_state || cfg.bad) ? ST_FIN : ST_PREP;
                end
            end
            ST_PREP:     step_next = ST_FILT_HI;
            ST_FILT_HI:  step_next = ST_FILT_LO;
            ST_FILT_LO:  step_next = ST_FILT_ADD;
            ST_FILT_ADD: step_next = ST_DER_HI;
            ST_DER_HI:   step_next = ST_DER_LO;
            ST_DER_LO:   step_next = ST_PROP;
            ST_PROP:     step_next = ST_INT_CAND;
            ST_INT_CAND: step_next = ST_INT_FLAG;
            ST_INT_FLAG: step_next = ST_INT_MUL;
            ST_INT_MUL:  step_next = ST_ROUND;
            ST_ROUND:    step_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    step_next = ST_IDLE;
            end
            default:     step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_reg == ST_FIN && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == ST_FIN && out_free)
            out_data_reg <= result;
    end

    assign in_stall  = (step_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/pidaw_checker.sv =====
// Port-level checks for the anti-windup PID controller, bound to the top level.
// Depends on pidaw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pidaw_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input pidaw_pkg::out_item_t out_data
);
    import pidaw_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    `ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall, "not busy after input transfer")

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    `ASSERT_IMPLIES(a_status_quiet, clk, rst_n, out_valid && out_data.status, out_data.drive == '0 && !out_data.sat_high && !out_data.sat_low && !out_data.integrated, "invalid-limit result not zero")

    `ASSERT_IMPLIES(a_sat_excl, clk, rst_n, out_valid, !(out_data.sat_high && out_data.sat_low), "both saturation flags set")

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/tb_pid_controller_antiwindup.sv =====
// Self-checking testbench for pid_controller_antiwindup: queued sample driver,
// result monitor and an in-bench fixed-point PID predictor with random idling.
// Depends on pidaw_pkg and the pid_controller_antiwindup RTL.
`timescale 1ns / 100ps

module tb_pid_controller_antiwindup;
    import pidaw_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_LEN    = 400;
    localparam int SETTLE      = 20;
    localparam int PRINT_CAP   = 200;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_wr    = 1'b0;
    logic [REG_ADDR_WIDTH-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    in_item_t                   in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    out_item_t                  out_data;

    // register mirror
    logic signed [31:0]         kp_r    = '0;
    logic signed [31:0]         ki_r    = '0;
    logic signed [31:0]         kd_r    = '0;
    logic [ALPHA_BITS:0]        alpha_r = ALPHA_ONE;
    logic signed [15:0]         dmin_r  = DRIVE_MIN_RST;
    logic signed [15:0]         dmax_r  = DRIVE_MAX_RST;
    logic signed [31:0]         amin_r  = ACCUM_MIN_RST;
    logic signed [31:0]         amax_r  = ACCUM_MAX_RST;

    // controller state mirror
    longint                     sum_m  = 0;
    longint                     last_m = 0;
    longint                     filt_m = 0;

    in_item_t                   sample_q[$];
    out_item_t                  drive_due_q[$];
    out_item_t                  want_item;

    int                         err_count = 0;
    int                         idle_pct  = 28;
    int                         hold_reqs = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;
    int                         cycle_cnt = 0;
    bit                         in_took   = 1'b0;

    pid_controller_antiwindup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic longint sat64(input longint x, input longint lo, input longint hi);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic int clamp16(input int x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    // one controller step on the mirrored state
    function automatic out_item_t calc_drive(input in_item_t s);
        longint    m, e, raw, hi, p_q, i_q, d_q, cand, c_out, lo_q, hi_q, o_q;
        longint    a, kp, ki, kd;
        logic      bad, up, dn, take;
        out_item_t r;
        kp  = kp_r;
        ki  = ki_r;
        kd  = kd_r;
        a   = longint'(alpha_r);
        bad = (dmin_r >= dmax_r) || (amin_r >= amax_r);
        r   = '0;
        r.status = bad;
        if (s.clear_state)
        begin
            sum_m  = 0;
            last_m = 0;
            filt_m = 0;
            return r;
        end
        if (bad)
            return r;
        if (a > longint'(ALPHA_ONE))
            a = longint'(ALPHA_ONE);
        m = longint'(s.measured);
        e = sat64(longint'(s.target) - m, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);

        raw    = sat64((last_m - m) <<< ALPHA_BITS, FILT_MIN, FILT_MAX);
        filt_m = sat64(filt_m + (((raw - filt_m) * a) >>> ALPHA_BITS), FILT_MIN, FILT_MAX);
        hi     = filt_m >>> ALPHA_BITS;
        d_q    = sat64(kd * hi + ((kd * (filt_m - (hi <<< ALPHA_BITS))) >>> ALPHA_BITS),
                       -TERM_LIM, TERM_LIM);

        p_q   = sat64(kp * e, -TERM_LIM, TERM_LIM);
        cand  = sat64(sum_m + e, longint'(amin_r), longint'(amax_r));
        i_q   = sat64(ki * cand, -TERM_LIM, TERM_LIM);
        c_out = p_q + i_q + d_q;

        lo_q = longint'(dmin_r) <<< FRAC;
        hi_q = longint'(dmax_r) <<< FRAC;
        up   = c_out > hi_q;
        dn   = c_out < lo_q;
        // conditional integration: hold the sum while pushing further into saturation
        take = (!up && !dn) || (up && e < 0) || (dn && e > 0);
        if (take)
            sum_m = cand;

        i_q = sat64(ki * sum_m, -TERM_LIM, TERM_LIM);
        o_q = sat64(p_q + i_q + d_q, lo_q, hi_q);
        o_q = (o_q + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        last_m = m;

        r.drive      = o_q[15:0];
        r.sat_high   = up;
        r.sat_low    = dn;
        r.integrated = take;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic add_sample(input int m, input int t, input bit c);
        in_item_t s;
        s.measured    = m[15:0];
        s.target      = t[15:0];
        s.clear_state = c;
        sample_q.push_back(s);
    endtask

    task automatic drain;
        while (sample_q.size() != 0 || drive_due_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_PROP_GAIN:   kp_r    = val;
            REG_INT_GAIN:    ki_r    = val;
            REG_DERIV_GAIN:  kd_r    = val;
            REG_DERIV_ALPHA: alpha_r = val[ALPHA_BITS:0];
            REG_DRIVE_MIN:   dmin_r  = val[15:0];
            REG_DRIVE_MAX:   dmax_r  = val[15:0];
            REG_ACCUM_MIN:   amin_r  = val;
            REG_ACCUM_MAX:   amax_r  = val;
            default: ;
        endcase
    endtask

    // waits for the block to go idle, then writes the whole register set
    task automatic set_config(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] alpha,
                              input logic [31:0] dmin, input logic [31:0] dmax,
                              input logic [31:0] amin, input logic [31:0] amax);
        drain();
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INT_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_DERIV_ALPHA, alpha);
        write_reg(REG_DRIVE_MIN, dmin);
        write_reg(REG_DRIVE_MAX, dmax);
        write_reg(REG_ACCUM_MIN, amin);
        write_reg(REG_ACCUM_MAX, amax);
        @(negedge clk);
        cfg_wr <= 1'b0;
    endtask

    function automatic logic [31:0] pick_gain(input bit wild, input int span);
        if (wild)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0;
                default: return $urandom();
            endcase
        end
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic rand_config(input bit wild, input bit broken);
        logic [31:0] kp, ki, kd, alpha, amin, amax, junk;
        int          dmin, dmax;
        kp   = pick_gain(wild, 1 << 18);
        ki   = pick_gain(wild, 1 << 15);
        kd   = pick_gain(wild, 1 << 18);
        junk = $urandom();
        case ($urandom_range(0, 4))
            0:       alpha = 0;
            1:       alpha = 32'(ALPHA_ONE);
            2:       alpha = $urandom_range(32'd65537, 32'd131071);
            default: alpha = $urandom_range(1, 65535);
        endcase
        alpha[31:ALPHA_BITS+1] = junk[31:ALPHA_BITS+1];
        if (wild)
        begin
            dmin = -32768;
            dmax = 32767;
            amin = 32'h8000_0000;
            amax = 32'h7FFF_FFFF;
        end
        else
        begin
            dmin = -int'($urandom_range(0, 4000));
            dmax = clamp16(dmin + 1 + int'($urandom_range(0, 8000)));
            amin = -int'($urandom_range(0, 300000));
            amax = amin + 1 + $urandom_range(0, 600000);
        end
        if (broken)
        begin
            if ($urandom_range(0, 1) == 0)
                dmax = dmin - int'($urandom_range(0, 1)) * int'(dmin > -32768);
            else
                amin = amax + $urandom_range(0, 1000);
        end
        set_config(kp, ki, kd, alpha, {junk[15:0], dmin[15:0]}, {junk[31:16], dmax[15:0]},
                   amin, amax);
    endtask

    // mostly slow-moving plant samples, some raw noise and the odd clear
    task automatic rand_samples(input int n);
        int          meas, tgt, k, sel;
        logic [31:0] r;
        meas = int'($urandom_range(0, 65535)) - 32768;
        tgt  = clamp16(meas + int'($urandom_range(0, 6000)) - 3000);
        for (k = 0; k < n; k++)
        begin
            r   = $urandom();
            sel = $urandom_range(0, 99);
            if (sel < 4)
                add_sample(int'(r[15:0]), int'(r[31:16]), 1'b1);
            else if (sel < 24)
                add_sample(int'(r[15:0]), int'(r[31:16]), 1'b0);
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    tgt = clamp16(meas + int'($urandom_range(0, 6000)) - 3000);
                meas = clamp16(meas + int'($urandom_range(0, 600)) - 300);
                add_sample(meas, tgt, 1'b0);
            end
        end
    endtask

    // input side: hold the payload until its transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            drive_due_q.push_back(calc_drive(in_data));
            void'(sample_q.pop_front());
            in_took = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            in_took = 1'b0;
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= sample_q[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: random stall, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_due_q.size() == 0)
                report_mismatch($sformatf("unexpected result drive %0d", out_data.drive));
            else
            begin
                want_item = drive_due_q.pop_front();
                if (out_data.drive !== want_item.drive
                    || out_data.sat_high !== want_item.sat_high
                    || out_data.sat_low !== want_item.sat_low
                    || out_data.integrated !== want_item.integrated
                    || out_data.status !== want_item.status)
                    report_mismatch($sformatf(
                        "got/want drive %0d/%0d hi %b/%b lo %b/%b int %b/%b st %b/%b",
                        out_data.drive, want_item.drive, out_data.sat_high,
                        want_item.sat_high, out_data.sat_low, want_item.sat_low,
                        out_data.integrated, want_item.integrated, out_data.status,
                        want_item.status));
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_pid_controller_antiwindup failed");
        $finish;
    end

    initial
    begin
        int ph;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: zero gains, widest limits
        add_sample(-32768, 32767, 1'b0);
        add_sample(32767, -32768, 1'b0);
        add_sample(0, 0, 1'b0);
        add_sample(123, -45, 1'b1);

        // unit proportional gain, narrow limits: saturation with and against the error
        set_config(65536, 16384, 32768, 65536, -1000, 1000, -5000, 5000);
        add_sample(0, 0, 1'b1);
        add_sample(0, 2000, 1'b0);
        add_sample(0, 2000, 1'b0);
        add_sample(0, -500, 1'b0);
        add_sample(1500, -32768, 1'b0);
        add_sample(1500, 3000, 1'b0);
        add_sample(-32768, 32767, 1'b0);
        add_sample(32767, -32768, 1'b0);

        // error sum running into its clamp
        set_config(0, 65536, 0, 65536, -32768, 32767, -3000, 3000);
        add_sample(0, 0, 1'b1);
        add_sample(0, 1000, 1'b0);
        add_sample(0, 1000, 1'b0);
        add_sample(0, 1000, 1'b0);
        add_sample(0, 1000, 1'b0);

        // frozen filter, then alpha above one
        set_config(0, 0, 65536, 0, -32768, 32767, 32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(100, 0, 1'b0);
        add_sample(-5000, 0, 1'b0);
        set_config(0, 0, 65536, 131071, -32768, 32767, 32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(2000, 0, 1'b0);
        add_sample(-2000, 0, 1'b0);

        // invalid drive limits, then invalid accumulator limits
        set_config(65536, 65536, 65536, 65536, 5, 5, -100, 100);
        add_sample(10, 20, 1'b0);
        add_sample(10, 20, 1'b1);
        set_config(65536, 65536, 65536, 65536, -100, 100, 100, -100);
        add_sample(0, 50, 1'b0);

        for (ph = 0; ph < 15; ph++)
        begin
            rand_config(ph % 5 == 4, ph % 6 == 5);
            idle_pct = (ph == 3) ? 0 : 28;
            rand_samples(100);
            if (ph == 7)
                hold_reqs++;
        end
        drain();

        if (err_count == 0)
            $display("tb_pid_controller_antiwindup passed");
        else
            $display("tb_pid_controller_antiwindup failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pidaw_pkg.sv
hdl/pidaw_regs.sv
hdl/pidaw_datapath.sv
hdl/pid_controller_antiwindup.sv
hdl/pidaw_checker.sv
tb/tb_pid_controller_antiwindup.sv
